/* rtl/ppbs_pkg.sv */
// Shared types and constants of the prioritized bandwidth budget scheduler.
package ppbs_pkg;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_UPDATE = 2'd2;
   localparam logic [1:0] REQ_REPORT = 2'd3;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_GRANT = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_SLOT   = 2'd1;
   localparam logic [1:0] ERR_BUSY   = 2'd2;
   localparam logic [1:0] ERR_REPORT = 2'd3;

   localparam logic [1:0] REG_UPLOAD_LIMIT   = 2'd0;
   localparam logic [1:0] REG_DOWNLOAD_LIMIT = 2'd1;
   localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd2;
   localparam logic [1:0] REG_MINIMUM_GRANT  = 2'd3;

   localparam logic [31:0] RESET_LIMIT     = 32'hFFFF_FFFF;
   localparam logic [15:0] RESET_WINDOW_MS = 16'd1000;
   localparam logic [15:0] RESET_MIN_GRANT = 16'd512;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAIT,
      ST_DECODE,
      ST_EMIT,
      ST_COUNT,
      ST_LEVEL,
      ST_DIV,
      ST_SCAN
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_ADD,
      OP_REMOVE,
      OP_UPDATE,
      OP_CNT_STEP,
      OP_NEXT_LEVEL,
      OP_BLOCK,
      OP_OPEN,
      OP_GRANT,
      OP_SCAN_STEP,
      OP_REPORT,
      OP_TO_DOWNLOAD,
      OP_PASS_END
   } op_type;

   typedef struct packed {
      logic [31:0] upload_limit;
      logic [31:0] download_limit;
      logic [15:0] window_length_ms;
      logic [15:0] minimum_grant;
   } cfg_type;

   typedef struct packed {
      op_type     op;
      logic       emit;
      logic [1:0] kind;
      logic [1:0] err;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       add_ok;
      logic       count_last;
      logic       level_end;
      logic       dir;
      logic       cnt_zero;
      logic       spent;
      logic       div_done;
      logic       scan_end;
      logic       scan_hit;
      logic       left_gt_bytes;
      logic       out_free;
   } status_type;

endpackage

/* rtl/ppbs_div.sv */
// Restoring divider: 32-bit dividend by a narrow count, one quotient bit per cycle.
module ppbs_div #(
   parameter int DIVISOR_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [31:0]          quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [4:0]           step_ff, step_in;
   logic [31:0]          q_ff, q_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, q_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, div_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* rtl/ppbs_ctrl.sv */
// Sequencer of the scheduler: decodes requests and steps the passes.
module ppbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ppbs_pkg::status_type status,
   output ppbs_pkg::cmd_type    cmd
);

   ppbs_pkg::state_type state_ff, state_in;
   ppbs_pkg::state_type ret_ff, ret_in;
   logic [1:0]          kind_ff, kind_in;
   logic [1:0]          err_ff, err_in;
   logic                pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppbs_pkg::ST_IDLE;
         ret_ff   <= ppbs_pkg::ST_IDLE;
         kind_ff  <= ppbs_pkg::KIND_ACK;
         err_ff   <= ppbs_pkg::ERR_NONE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         kind_ff  <= kind_in;
         err_ff   <= err_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      kind_in  = kind_ff;
      err_in   = err_ff;
      pass_in  = pass_ff;
      in_ready = 1'b0;
      cmd.op   = ppbs_pkg::OP_NONE;
      cmd.emit = 1'b0;
      cmd.kind = kind_ff;
      cmd.err  = err_ff;
      case (state_ff)
         ppbs_pkg::ST_IDLE, ppbs_pkg::ST_WAIT: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op   = ppbs_pkg::OP_CAPTURE;
               state_in = ppbs_pkg::ST_DECODE;
            end
         end
         ppbs_pkg::ST_DECODE: begin
            kind_in  = ppbs_pkg::KIND_ACK;
            err_in   = ppbs_pkg::ERR_NONE;
            ret_in   = pass_ff ? ppbs_pkg::ST_WAIT : ppbs_pkg::ST_IDLE;
            state_in = ppbs_pkg::ST_EMIT;
            if (status.req_type == ppbs_pkg::REQ_REPORT) begin
               if (!pass_ff) begin
                  kind_in = ppbs_pkg::KIND_ERROR;
                  err_in  = ppbs_pkg::ERR_REPORT;
               end else begin
                  cmd.op   = ppbs_pkg::OP_REPORT;
                  state_in = status.left_gt_bytes ? ppbs_pkg::ST_SCAN : ppbs_pkg::ST_LEVEL;
               end
            end else if (pass_ff) begin
               kind_in = ppbs_pkg::KIND_ERROR;
               err_in  = ppbs_pkg::ERR_BUSY;
            end else begin
               case (status.req_type)
                  ppbs_pkg::REQ_ADD: begin
                     if (status.add_ok) begin
                        cmd.op = ppbs_pkg::OP_ADD;
                     end else begin
                        kind_in = ppbs_pkg::KIND_ERROR;
                        err_in  = ppbs_pkg::ERR_SLOT;
                     end
                  end
                  ppbs_pkg::REQ_REMOVE: begin
                     cmd.op = ppbs_pkg::OP_REMOVE;
                  end
                  default: begin
                     cmd.op   = ppbs_pkg::OP_UPDATE;
                     pass_in  = 1'b1;
                     state_in = ppbs_pkg::ST_COUNT;
                  end
               endcase
            end
         end
         ppbs_pkg::ST_COUNT: begin
            cmd.op = ppbs_pkg::OP_CNT_STEP;
            if (status.count_last) begin
               state_in = ppbs_pkg::ST_LEVEL;
            end
         end
         ppbs_pkg::ST_LEVEL: begin
            if (status.level_end) begin
               if (!status.dir) begin
                  cmd.op   = ppbs_pkg::OP_TO_DOWNLOAD;
                  state_in = ppbs_pkg::ST_COUNT;
               end else begin
                  cmd.op   = ppbs_pkg::OP_PASS_END;
                  pass_in  = 1'b0;
                  kind_in  = ppbs_pkg::KIND_DONE;
                  err_in   = ppbs_pkg::ERR_NONE;
                  ret_in   = ppbs_pkg::ST_IDLE;
                  state_in = ppbs_pkg::ST_EMIT;
               end
            end else if (status.cnt_zero) begin
               cmd.op = ppbs_pkg::OP_NEXT_LEVEL;
            end else if (status.spent) begin
               cmd.op = ppbs_pkg::OP_BLOCK;
            end else begin
               cmd.op   = ppbs_pkg::OP_OPEN;
               state_in = ppbs_pkg::ST_DIV;
            end
         end
         ppbs_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.op   = ppbs_pkg::OP_GRANT;
               state_in = ppbs_pkg::ST_SCAN;
            end
         end
         ppbs_pkg::ST_SCAN: begin
            if (status.scan_end) begin
               cmd.op   = ppbs_pkg::OP_NEXT_LEVEL;
               state_in = ppbs_pkg::ST_LEVEL;
            end else if (status.scan_hit) begin
               kind_in  = ppbs_pkg::KIND_GRANT;
               err_in   = ppbs_pkg::ERR_NONE;
               ret_in   = ppbs_pkg::ST_WAIT;
               state_in = ppbs_pkg::ST_EMIT;
            end else begin
               cmd.op = ppbs_pkg::OP_SCAN_STEP;
            end
         end
         ppbs_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ppbs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/ppbs_dp.sv */
// Datapath of the scheduler: slot table, budgets, pass position and result register.
module ppbs_dp #(
   parameter int MAX_CLIENTS     = 16,
   parameter int PRIORITY_LEVELS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ppbs_pkg::cfg_type    cfg,
   input  ppbs_pkg::cmd_type    cmd,
   output ppbs_pkg::status_type status,
   input  logic [1:0]           in_type,
   input  logic [3:0]           in_slot,
   input  logic [31:0]          in_now,
   input  logic [15:0]          in_wmask,
   input  logic [15:0]          in_rmask,
   input  logic [31:0]          in_bytes,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic [1:0]           out_kind,
   output logic [3:0]           out_slot,
   output logic                 out_dir,
   output logic [31:0]          out_bytes,
   output logic [15:0]          out_wblk,
   output logic [15:0]          out_rblk,
   output logic [1:0]           out_err
);

   localparam int SW  = $clog2(MAX_CLIENTS);
   localparam int PW  = $clog2(MAX_CLIENTS + 1);
   localparam int LW  = $clog2(PRIORITY_LEVELS);
   localparam int LCW = $clog2(PRIORITY_LEVELS + 1);
   localparam int CW  = $clog2(MAX_CLIENTS + 1);
   localparam int MW  = (MAX_CLIENTS > 16) ? MAX_CLIENTS : 16;
   localparam int XW  = ((SW > 4) ? SW : 4) + 1;

   logic [MAX_CLIENTS-1:0] valid_ff, valid_in;
   logic [MAX_CLIENTS-1:0] rmv_ff, rmv_in;
   logic [MAX_CLIENTS-1:0] wblk_ff, wblk_in;
   logic [MAX_CLIENTS-1:0] rblk_ff, rblk_in;
   logic [LW-1:0]          wlv_ff [MAX_CLIENTS];
   logic [LW-1:0]          wlv_in [MAX_CLIENTS];
   logic [LW-1:0]          rlv_ff [MAX_CLIENTS];
   logic [LW-1:0]          rlv_in [MAX_CLIENTS];
   logic [CW-1:0]          cnt_ff [PRIORITY_LEVELS];
   logic [CW-1:0]          cnt_in [PRIORITY_LEVELS];
   logic [15:0]            snapw_ff, snapw_in, snapr_ff, snapr_in;
   logic [31:0]            upused_ff, upused_in, dnused_ff, dnused_in;
   logic [31:0]            wstart_ff, wstart_in;
   logic [SW-1:0]          cidx_ff, cidx_in;
   logic                   dir_ff, dir_in;
   logic [LCW-1:0]         level_ff, level_in;
   logic [PW-1:0]          slot_ff, slot_in;
   logic [31:0]            left_ff, left_in, grant_ff, grant_in;
   logic [1:0]             rq_type_ff;
   logic [3:0]             rq_slot_ff;
   logic [31:0]            rq_now_ff, rq_bytes_ff;
   logic [15:0]            rq_wm_ff, rq_rm_ff;
   logic                   ovalid_ff, ovalid_in;
   logic [1:0]             okind_ff, oerr_ff;
   logic [3:0]             oslot_ff;
   logic                   odir_ff;
   logic [31:0]            obytes_ff;
   logic [15:0]            owblk_ff, orblk_ff;

   logic [MW-1:0]          snapw_x, snapr_x, wblk_x, rblk_x;
   logic [MAX_CLIENTS-1:0] rdy_cur;
   logic [LW-1:0]          lv_cur [MAX_CLIENTS];
   logic [31:0]            used_cur, limit_cur, elapsed;
   logic [XW-1:0]          slot_x;
   logic [SW-1:0]          add_idx, scan_idx;
   logic [LW-1:0]          lvl_idx, cidx_lv;
   logic [32:0]            used_sum;
   logic [31:0]            used_sat;
   logic                   div_start, div_done;
   logic [31:0]            div_q;

   always_comb begin
      snapw_x   = MW'(snapw_ff);
      snapr_x   = MW'(snapr_ff);
      wblk_x    = MW'(wblk_ff);
      rblk_x    = MW'(rblk_ff);
      rdy_cur   = dir_ff ? snapr_x[MAX_CLIENTS-1:0] : snapw_x[MAX_CLIENTS-1:0];
      for (int s = 0; s < MAX_CLIENTS; s++) begin
         lv_cur[s] = dir_ff ? rlv_ff[s] : wlv_ff[s];
      end
      used_cur  = dir_ff ? dnused_ff : upused_ff;
      limit_cur = dir_ff ? cfg.download_limit : cfg.upload_limit;
      elapsed   = rq_now_ff - wstart_ff;
      slot_x    = XW'(rq_slot_ff);
      add_idx   = slot_x[SW-1:0];
      scan_idx  = slot_ff[SW-1:0];
      lvl_idx   = level_ff[LW-1:0];
      cidx_lv   = lv_cur[cidx_ff];
      used_sum  = {1'b0, used_cur} + {1'b0, rq_bytes_ff};
      used_sat  = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];
   end

   always_comb begin
      status.req_type      = rq_type_ff;
      status.add_ok        = (slot_x < XW'(MAX_CLIENTS)) && !valid_ff[add_idx];
      status.count_last    = (cidx_ff == SW'(MAX_CLIENTS - 1));
      status.level_end     = (level_ff == LCW'(PRIORITY_LEVELS));
      status.dir           = dir_ff;
      status.cnt_zero      = (cnt_ff[lvl_idx] == '0);
      status.spent         = (used_cur >= limit_cur);
      status.div_done      = div_done;
      status.scan_end      = (slot_ff == PW'(MAX_CLIENTS));
      status.scan_hit      = valid_ff[scan_idx] && rdy_cur[scan_idx]
                             && (lv_cur[scan_idx] == lvl_idx);
      status.left_gt_bytes = (rq_bytes_ff < left_ff);
      status.out_free      = !ovalid_ff || out_ready;
   end

   assign div_start = (cmd.op == ppbs_pkg::OP_OPEN);

   ppbs_div #(
      .DIVISOR_W(CW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(limit_cur - used_cur),
      .divisor (cnt_ff[lvl_idx]),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      valid_in  = valid_ff;
      rmv_in    = rmv_ff;
      wblk_in   = wblk_ff;
      rblk_in   = rblk_ff;
      wlv_in    = wlv_ff;
      rlv_in    = rlv_ff;
      cnt_in    = cnt_ff;
      snapw_in  = snapw_ff;
      snapr_in  = snapr_ff;
      upused_in = upused_ff;
      dnused_in = dnused_ff;
      wstart_in = wstart_ff;
      cidx_in   = cidx_ff;
      dir_in    = dir_ff;
      level_in  = level_ff;
      slot_in   = slot_ff;
      left_in   = left_ff;
      grant_in  = grant_ff;
      case (cmd.op)
         ppbs_pkg::OP_ADD: begin
            valid_in[add_idx] = 1'b1;
            rmv_in[add_idx]   = 1'b0;
            wblk_in[add_idx]  = 1'b0;
            rblk_in[add_idx]  = 1'b0;
            wlv_in[add_idx]   = '0;
            rlv_in[add_idx]   = '0;
         end
         ppbs_pkg::OP_REMOVE: begin
            if ((slot_x < XW'(MAX_CLIENTS)) && valid_ff[add_idx]) begin
               rmv_in[add_idx] = 1'b1;
            end
         end
         ppbs_pkg::OP_UPDATE: begin
            if (elapsed > {16'd0, cfg.window_length_ms}) begin
               wblk_in   = '0;
               rblk_in   = '0;
               for (int s = 0; s < MAX_CLIENTS; s++) begin
                  wlv_in[s] = '0;
                  rlv_in[s] = '0;
               end
               wstart_in = rq_now_ff;
               upused_in = '0;
               dnused_in = '0;
            end
            valid_in = valid_ff & ~rmv_ff;
            rmv_in   = '0;
            snapw_in = rq_wm_ff;
            snapr_in = rq_rm_ff;
            dir_in   = 1'b0;
            level_in = '0;
            slot_in  = '0;
            cidx_in  = '0;
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
               cnt_in[l] = '0;
            end
         end
         ppbs_pkg::OP_CNT_STEP: begin
            if (valid_ff[cidx_ff] && rdy_cur[cidx_ff]) begin
               cnt_in[cidx_lv] = CW'(cnt_ff[cidx_lv] + 1'b1);
            end
            cidx_in = (cidx_ff == SW'(MAX_CLIENTS - 1)) ? '0 : SW'(cidx_ff + 1'b1);
         end
         ppbs_pkg::OP_NEXT_LEVEL: begin
            level_in = LCW'(level_ff + 1'b1);
            slot_in  = '0;
         end
         ppbs_pkg::OP_BLOCK: begin
            for (int s = 0; s < MAX_CLIENTS; s++) begin
               if (valid_ff[s] && rdy_cur[s] && (lv_cur[s] == lvl_idx)) begin
                  if (dir_ff) begin
                     rblk_in[s] = 1'b1;
                  end else begin
                     wblk_in[s] = 1'b1;
                  end
               end
            end
            level_in = LCW'(level_ff + 1'b1);
            slot_in  = '0;
         end
         ppbs_pkg::OP_OPEN: begin
            left_in = limit_cur - used_cur;
            slot_in = '0;
         end
         ppbs_pkg::OP_GRANT: begin
            grant_in = (div_q < {16'd0, cfg.minimum_grant}) ? {16'd0, cfg.minimum_grant} : div_q;
         end
         ppbs_pkg::OP_SCAN_STEP: begin
            slot_in = PW'(slot_ff + 1'b1);
         end
         ppbs_pkg::OP_REPORT: begin
            if (dir_ff) begin
               dnused_in = used_sat;
            end else begin
               upused_in = used_sat;
            end
            if ((rq_bytes_ff != '0) && (level_ff < LCW'(PRIORITY_LEVELS - 1))) begin
               if (dir_ff) begin
                  rlv_in[scan_idx] = LW'(level_ff + 1'b1);
               end else begin
                  wlv_in[scan_idx] = LW'(level_ff + 1'b1);
               end
            end
            if (rq_bytes_ff < left_ff) begin
               left_in = left_ff - rq_bytes_ff;
               slot_in = PW'(slot_ff + 1'b1);
            end else begin
               left_in  = '0;
               level_in = LCW'(level_ff + 1'b1);
               slot_in  = '0;
            end
         end
         ppbs_pkg::OP_TO_DOWNLOAD: begin
            dir_in   = 1'b1;
            level_in = '0;
            slot_in  = '0;
            cidx_in  = '0;
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
               cnt_in[l] = '0;
            end
         end
         ppbs_pkg::OP_PASS_END: begin
            dir_in   = 1'b0;
            level_in = '0;
            slot_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.emit) begin
         ovalid_in = 1'b1;
      end else if (out_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rmv_ff    <= '0;
         wblk_ff   <= '0;
         rblk_ff   <= '0;
         for (int s = 0; s < MAX_CLIENTS; s++) begin
            wlv_ff[s] <= '0;
            rlv_ff[s] <= '0;
         end
         snapw_ff  <= '0;
         snapr_ff  <= '0;
         upused_ff <= '0;
         dnused_ff <= '0;
         wstart_ff <= '0;
         cidx_ff   <= '0;
         dir_ff    <= 1'b0;
         level_ff  <= '0;
         slot_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rmv_ff    <= rmv_in;
         wblk_ff   <= wblk_in;
         rblk_ff   <= rblk_in;
         wlv_ff    <= wlv_in;
         rlv_ff    <= rlv_in;
         snapw_ff  <= snapw_in;
         snapr_ff  <= snapr_in;
         upused_ff <= upused_in;
         dnused_ff <= dnused_in;
         wstart_ff <= wstart_in;
         cidx_ff   <= cidx_in;
         dir_ff    <= dir_in;
         level_ff  <= level_in;
         slot_ff   <= slot_in;
         ovalid_ff <= ovalid_in;
      end
      cnt_ff   <= cnt_in;
      left_ff  <= left_in;
      grant_ff <= grant_in;
      if (cmd.op == ppbs_pkg::OP_CAPTURE) begin
         rq_type_ff  <= in_type;
         rq_slot_ff  <= in_slot;
         rq_now_ff   <= in_now;
         rq_wm_ff    <= in_wmask;
         rq_rm_ff    <= in_rmask;
         rq_bytes_ff <= in_bytes;
      end
      if (cmd.emit) begin
         okind_ff <= cmd.kind;
         oerr_ff  <= cmd.err;
         owblk_ff <= wblk_x[15:0];
         orblk_ff <= rblk_x[15:0];
         if (cmd.kind == ppbs_pkg::KIND_GRANT) begin
            oslot_ff  <= 4'(slot_ff);
            odir_ff   <= dir_ff;
            obytes_ff <= grant_ff;
         end else begin
            oslot_ff  <= '0;
            odir_ff   <= 1'b0;
            obytes_ff <= '0;
         end
      end
   end

   assign out_valid = ovalid_ff;
   assign out_kind  = okind_ff;
   assign out_slot  = oslot_ff;
   assign out_dir   = odir_ff;
   assign out_bytes = obytes_ff;
   assign out_wblk  = owblk_ff;
   assign out_rblk  = orblk_ff;
   assign out_err   = oerr_ff;

endmodule

/* rtl/prioritized_bandwidth_budget_scheduler.sv */
// Top level of the prioritized bandwidth budget scheduler: register port and block wiring.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  tuser: req_type; tdata: request fields
//   rsp_     out        rsp_tvalid/rsp_tready  tuser: result_kind; tdata: result fields
//   csr_     in         APB, pready tied high  four 32-bit registers at 0x0..0xC
//
// Add, remove, report-while-idle and every rejected request pass decode, then the
// output load, which waits for a free output register, before the result word is valid.
// An update or an accepted report walks the pass: each direction first counts
// its ready clients, one slot a cycle, then visits each level in turn, and a
// level that is served opens its budget, waits for the bit-serial budget
// divider and then scans its slots one slot a cycle, pausing at each grant
// until the report for it arrives.
// Reset is synchronous and clears the slot table, the usage counters and the pass position.
// A stalled result word holds in the output register; the next request word is
// still taken and its result waits until the register is free.
module prioritized_bandwidth_budget_scheduler #(
   parameter int MAX_CLIENTS     = 16,
   parameter int PRIORITY_LEVELS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: client_slot[3:0], now_ms[35:4], write_ready_mask[51:36],
   // read_ready_mask[67:52], bytes_done[99:68], zero pad [103:100]
   input  logic [103:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: grant_slot[3:0], grant_direction[4], grant_bytes[36:5],
   // write_blocked_mask[52:37], read_blocked_mask[68:53], error_code[70:69], zero [71]
   output logic [71:0]  rsp_tdata,
   // tuser: result_kind[1:0]
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   ppbs_pkg::cfg_type    cfg_ff, cfg_in;
   ppbs_pkg::cmd_type    cmd;
   ppbs_pkg::status_type status;
   logic                 csr_write;
   logic                 out_dir;
   logic [3:0]           out_slot;
   logic [31:0]          out_bytes;
   logic [15:0]          out_wblk, out_rblk;
   logic [1:0]           out_err;

   // The register port writes on the access phase; there are no wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            ppbs_pkg::REG_UPLOAD_LIMIT:   cfg_in.upload_limit     = csr_pwdata;
            ppbs_pkg::REG_DOWNLOAD_LIMIT: cfg_in.download_limit   = csr_pwdata;
            ppbs_pkg::REG_WINDOW_LENGTH:  cfg_in.window_length_ms = csr_pwdata[15:0];
            ppbs_pkg::REG_MINIMUM_GRANT:  cfg_in.minimum_grant    = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ppbs_pkg::REG_UPLOAD_LIMIT:   csr_prdata = cfg_ff.upload_limit;
         ppbs_pkg::REG_DOWNLOAD_LIMIT: csr_prdata = cfg_ff.download_limit;
         ppbs_pkg::REG_WINDOW_LENGTH:  csr_prdata = {16'd0, cfg_ff.window_length_ms};
         ppbs_pkg::REG_MINIMUM_GRANT:  csr_prdata = {16'd0, cfg_ff.minimum_grant};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upload_limit     <= ppbs_pkg::RESET_LIMIT;
         cfg_ff.download_limit   <= ppbs_pkg::RESET_LIMIT;
         cfg_ff.window_length_ms <= ppbs_pkg::RESET_WINDOW_MS;
         cfg_ff.minimum_grant    <= ppbs_pkg::RESET_MIN_GRANT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer only steers; all state of the table and the pass position sits in the datapath.
   ppbs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .status  (status),
      .cmd     (cmd)
   );

   ppbs_dp #(
      .MAX_CLIENTS    (MAX_CLIENTS),
      .PRIORITY_LEVELS(PRIORITY_LEVELS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .status   (status),
      .in_type  (req_tuser),
      .in_slot  (req_tdata[3:0]),
      .in_now   (req_tdata[35:4]),
      .in_wmask (req_tdata[51:36]),
      .in_rmask (req_tdata[67:52]),
      .in_bytes (req_tdata[99:68]),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .out_kind (rsp_tuser),
      .out_slot (out_slot),
      .out_dir  (out_dir),
      .out_bytes(out_bytes),
      .out_wblk (out_wblk),
      .out_rblk (out_rblk),
      .out_err  (out_err)
   );

   assign rsp_tdata = {1'b0, out_err, out_rblk, out_wblk, out_bytes, out_dir, out_slot};

endmodule
